[sv/snr_pkg.sv]
// shared types and constants of the spectral noise subtraction unit
package snr_pkg;

   // field widths
   localparam int CHANNEL_W   = 6;
   localparam int ENERGY_W    = 32;
   localparam int COEF_W      = 16;
   localparam int UPSCALE_W   = 5;
   localparam int FSHIFT_W    = 6;
   localparam int PROD_W      = ENERGY_W + COEF_W;
   localparam int ACC_W       = PROD_W + 1;
   localparam int CH_CODES    = 1 << CHANNEL_W;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COEF_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_EVEN_SMOOTHING = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ODD_SMOOTHING  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EVEN_KEEP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ODD_KEEP       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FLOOR_FRACTION = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_UPSCALE_SHIFT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FRACTION_SHIFT = 3'd6;

   // reset value of the fraction shift
   localparam logic [FSHIFT_W-1:0] FSHIFT_RESET = 6'd14;

   // register file contents seen by the datapath
   typedef struct packed {
      logic [COEF_W-1:0]    even_smoothing;
      logic [COEF_W-1:0]    odd_smoothing;
      logic [COEF_W-1:0]    even_keep;
      logic [COEF_W-1:0]    odd_keep;
      logic [COEF_W-1:0]    floor_fraction;
      logic [UPSCALE_W-1:0] upscale_shift;
      logic [FSHIFT_W-1:0]  fraction_shift;
   } snr_cfg_type;

   // pipeline occupancy reported to the front end
   typedef struct packed {
      logic in_open;   // first stage can take a beat this cycle
      logic s1_valid;
      logic s2_valid;
      logic s2_write;  // second stage writes its estimate back this cycle
   } snr_status_type;

endpackage

[sv/snr_if.sv]
// handshake channels of the spectral noise subtraction unit
interface snr_req_if
   import snr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic [ENERGY_W-1:0]  energy;

   modport source (output valid, output channel, output energy, input ready);
   modport sink   (input valid, input channel, input energy, output ready);
endinterface

interface snr_rsp_if
   import snr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] cleaned;

   modport source (output valid, output cleaned, input ready);
   modport sink   (input valid, input cleaned, output ready);
endinterface

[sv/spectral_noise_subtraction_unit.sv]
// top level of the spectral noise subtraction unit
//
// Each req beat carries a channel index and its energy; each rsp beat carries
// the cleaned energy for that beat, in order, one rsp beat per req beat.
// The csr port writes the coefficient and shift registers; write it only when
// no beat is in flight.
// Each beat passes through the pipeline stages and then the output register before its rsp beat is valid.
// Throughput: one beat per cycle while req ready is high; the noise store is read
// when a beat is taken and written back from the second stage, so a beat for the
// same slot as the beat just ahead of it waits until that write is made and then
// takes the written value by a bypass; it waits longer while the rsp side stalls.
// Reset: synchronous; afterwards the store is cleared one slot a cycle, so
// req ready stays low until the clearing pass ends. Registers are writable during
// that pass.
// Stall: a result held in the output register does not block the stages
// behind it until they fill; then req ready drops.
module spectral_noise_subtraction_unit
   import snr_pkg::*;
#(
   parameter int NUM_CHANNELS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   snr_req_if.sink                req_bus,
   snr_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SLOT_W = $clog2(NUM_CHANNELS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CHANNELS - 1);

   snr_cfg_type cfg_ff;

   logic              clr_busy_ff;
   logic [SLOT_W-1:0] clr_addr_ff;

   logic [SLOT_W-1:0]   in_slot;
   logic                hazard;
   logic                accept;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [ENERGY_W-1:0] mem_wdata;
   logic [ENERGY_W-1:0] rd_data;
   logic [SLOT_W-1:0]   wb_slot;
   logic [ENERGY_W-1:0] wb_data;
   logic [SLOT_W-1:0]   s1_slot;
   snr_status_type      status;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.even_smoothing <= '0;
         cfg_ff.odd_smoothing  <= '0;
         cfg_ff.even_keep      <= '0;
         cfg_ff.odd_keep       <= '0;
         cfg_ff.floor_fraction <= '0;
         cfg_ff.upscale_shift  <= '0;
         cfg_ff.fraction_shift <= FSHIFT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_EVEN_SMOOTHING: cfg_ff.even_smoothing <= csr_wdata;
            REG_ODD_SMOOTHING:  cfg_ff.odd_smoothing  <= csr_wdata;
            REG_EVEN_KEEP:      cfg_ff.even_keep      <= csr_wdata;
            REG_ODD_KEEP:       cfg_ff.odd_keep       <= csr_wdata;
            REG_FLOOR_FRACTION: cfg_ff.floor_fraction <= csr_wdata;
            REG_UPSCALE_SHIFT:  cfg_ff.upscale_shift  <= csr_wdata[UPSCALE_W-1:0];
            REG_FRACTION_SHIFT: cfg_ff.fraction_shift <= csr_wdata[FSHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // clearing pass over the store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_SLOT) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // channel to slot, wrapped at the store depth
   always_comb begin
      in_slot = '0;
      for (int i = 0; i < CH_CODES; i++) begin
         if (req_bus.channel == CHANNEL_W'(i)) begin
            in_slot = SLOT_W'(i % NUM_CHANNELS);
         end
      end
   end

   // hold off a beat whose slot is still being updated ahead of it
   assign hazard = (status.s1_valid && (s1_slot == in_slot))
                || (status.s2_valid && !status.s2_write && (wb_slot == in_slot));

   assign req_bus.ready = !clr_busy_ff && status.in_open && !hazard;
   assign accept        = req_bus.valid && req_bus.ready;

   // store write port shared by the clearing pass and the write-back
   assign mem_we    = clr_busy_ff || status.s2_write;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wb_slot;
   assign mem_wdata = clr_busy_ff ? '0 : wb_data;

   snr_noise_mem #(
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_slot),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   snr_pipe #(
      .SLOT_W (SLOT_W)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .in_slot     (in_slot),
      .in_odd      (req_bus.channel[0]),
      .in_energy   (req_bus.energy),
      .rd_data     (rd_data),
      .wb_slot     (wb_slot),
      .wb_data     (wb_data),
      .status      (status),
      .s1_slot     (s1_slot),
      .out_ready   (rsp_bus.ready),
      .out_valid   (rsp_bus.valid),
      .out_cleaned (rsp_bus.cleaned)
   );

endmodule

[sv/snr_noise_mem.sv]
// noise estimate store: one write port, one registered read port
module snr_noise_mem
   import snr_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [ENERGY_W-1:0] rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [ENERGY_W-1:0] wr_data
);

   logic [ENERGY_W-1:0] mem [DEPTH];
   logic [ENERGY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/snr_pipe.sv]
// estimate update and output arithmetic, three stages and an output register
module snr_pipe
   import snr_pkg::*;
#(
   parameter int SLOT_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  snr_cfg_type         cfg,
   // accepted beat
   input  logic                accept,
   input  logic [SLOT_W-1:0]   in_slot,
   input  logic                in_odd,
   input  logic [ENERGY_W-1:0] in_energy,
   // estimate read at acceptance
   input  logic [ENERGY_W-1:0] rd_data,
   // write-back of the new estimate
   output logic [SLOT_W-1:0]   wb_slot,
   output logic [ENERGY_W-1:0] wb_data,
   // occupancy for the interlock
   output snr_status_type      status,
   output logic [SLOT_W-1:0]   s1_slot,
   // result channel
   input  logic                out_ready,
   output logic                out_valid,
   output logic [ENERGY_W-1:0] out_cleaned
);

   // stage valids and advance enables
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   logic en1, en2, en3, eno;

   // first stage registers
   logic [SLOT_W-1:0]   slot1_ff;
   logic                odd1_ff;
   logic [ENERGY_W-1:0] energy1_ff;
   logic                byp_ff;
   logic [ENERGY_W-1:0] byp_data_ff;

   // second stage registers
   logic [SLOT_W-1:0]   slot2_ff;
   logic [ENERGY_W-1:0] scaled2_ff;
   logic [PROD_W-1:0]   psig2_ff, pnoise2_ff, pfloor2_ff;

   // third stage registers
   logic [ENERGY_W-1:0] scaled3_ff, noise3_ff, floor3_ff;

   // output register
   logic [ENERGY_W-1:0] cleaned_ff;

   // first stage arithmetic
   logic [COEF_W-1:0]   smooth1, keep1;
   logic [ENERGY_W-1:0] scaled1, old_noise1;
   logic [PROD_W-1:0]   psig1, pnoise1, pfloor1;

   // second stage arithmetic
   logic [ACC_W-1:0]    acc2;
   logic [ENERGY_W-1:0] noise2, floor2;

   // third stage arithmetic
   logic [ENERGY_W-1:0] diff3, sub3, cleaned3;

   // a stage moves when the one after it is empty or moving
   assign eno = !vo_ff || out_ready;
   assign en3 = !v3_ff || eno;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign v1_in = en1 ? accept : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign vo_in = eno ? v3_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   // capture the beat, and note a write-back to the same slot at the read edge
   always_ff @(posedge clock) begin
      if (accept) begin
         slot1_ff    <= in_slot;
         odd1_ff     <= in_odd;
         energy1_ff  <= in_energy;
         byp_ff      <= status.s2_write && (wb_slot == in_slot);
         byp_data_ff <= wb_data;
      end
   end

   // coefficient pair by parity, three products in parallel
   assign smooth1    = odd1_ff ? cfg.odd_smoothing : cfg.even_smoothing;
   assign keep1      = odd1_ff ? cfg.odd_keep : cfg.even_keep;
   assign scaled1    = energy1_ff << cfg.upscale_shift;
   assign old_noise1 = byp_ff ? byp_data_ff : rd_data;
   assign psig1      = {{COEF_W{1'b0}}, scaled1} * {{ENERGY_W{1'b0}}, smooth1};
   assign pnoise1    = {{COEF_W{1'b0}}, old_noise1} * {{ENERGY_W{1'b0}}, keep1};
   assign pfloor1    = {{COEF_W{1'b0}}, energy1_ff}
                     * {{ENERGY_W{1'b0}}, cfg.floor_fraction};

   always_ff @(posedge clock) begin
      if (en2) begin
         slot2_ff   <= slot1_ff;
         scaled2_ff <= scaled1;
         psig2_ff   <= psig1;
         pnoise2_ff <= pnoise1;
         pfloor2_ff <= pfloor1;
      end
   end

   // new estimate and floor, fraction removed
   assign acc2   = {1'b0, psig2_ff} + {1'b0, pnoise2_ff};
   assign noise2 = ENERGY_W'(acc2 >> cfg.fraction_shift);
   assign floor2 = ENERGY_W'(pfloor2_ff >> cfg.fraction_shift);

   always_ff @(posedge clock) begin
      if (en3) begin
         scaled3_ff <= scaled2_ff;
         noise3_ff  <= noise2;
         floor3_ff  <= floor2;
      end
   end

   // subtraction floored at zero, then the larger of it and the floor
   assign diff3    = (scaled3_ff > noise3_ff) ? scaled3_ff - noise3_ff : '0;
   assign sub3     = diff3 >> cfg.upscale_shift;
   assign cleaned3 = (sub3 > floor3_ff) ? sub3 : floor3_ff;

   always_ff @(posedge clock) begin
      if (eno) begin
         cleaned_ff <= cleaned3;
      end
   end

   // write-back and status
   assign wb_slot         = slot2_ff;
   assign wb_data         = noise2;
   assign status.in_open  = en1;
   assign status.s1_valid = v1_ff;
   assign status.s2_valid = v2_ff;
   assign status.s2_write = v2_ff && en3;
   assign s1_slot         = slot1_ff;

   assign out_valid   = vo_ff;
   assign out_cleaned = cleaned_ff;

endmodule
